/* hdl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* hdl/scc_pkg.sv */
`default_nettype none

package scc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

  // token classes
  localparam logic [1:0] KIND_PUNCT  = 2'd1;
  localparam logic [1:0] KIND_ASSIGN = 2'd2;

  // punctuation codes
  localparam logic [2:0] P_LPAREN = 3'd1;
  localparam logic [2:0] P_LBRACE = 3'd2;
  localparam logic [2:0] P_LBRACK = 3'd3;
  localparam logic [2:0] P_RPAREN = 3'd4;
  localparam logic [2:0] P_RBRACE = 3'd5;
  localparam logic [2:0] P_RBRACK = 3'd6;
  localparam logic [2:0] P_SEMI   = 3'd7;

  // stack entry with no opener
  localparam logic [1:0] OPEN_NONE = 2'd0;

  typedef enum logic [2:0] {
    V_TERM     = 3'd0,
    V_COMPLETE = 3'd1,
    V_UNBAL    = 3'd2,
    V_DANGLE   = 3'd3,
    V_OVERFLOW = 3'd4
  } verdict_t;

  // shift control for the row of stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hdl/scc_cell.sv */
`default_nettype none

// one stack entry: takes the entry above on push, the one below on pop
module scc_cell (
  input  wire logic              clk,
  input  wire scc_pkg::cell_ctl_t ctl,
  input  wire logic [1:0]        from_up,
  input  wire logic [1:0]        from_down,
  output logic [1:0]             entry
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry <= from_up;
    end else if (ctl.pop) begin
      entry <= from_down;
    end
  end

endmodule

`default_nettype wire

/* hdl/statement_completeness_checker_core.sv */
// statement completeness checker
//
// input channel s_*: one lexed token per item. s_tdata packs kind, punct_code
// and is_inc_dec; s_tlast marks the final token of a sequence. only the
// final token produces a result item.
// output channel m_*: one verdict item per sequence, m_tdata packs complete
// and verdict.
//
// throughput: one token per cycle while s_tready is high. the bracket stack is
// a row of identical cells that shift down on a push and up on a pop, so the
// only entry ever compared is the one in the first cell and every token
// finishes its stack update in the cycle it is accepted.
// result: the verdict is registered in the output register, or in the skid
// entry while an earlier verdict is stalled, when the last token is accepted.
// stall: an output register plus one skid entry sit on the result side.
// tokens keep flowing while a verdict waits; s_tready drops only once a
// second verdict is parked behind a stalled one.
// reset: level, mismatch and overflow flags and both output entries clear;
// stack cells hold no reset and are only read below the level. all sequence
// state also clears after each verdict.
`default_nettype none

module statement_completeness_checker_core (
  input  wire logic       clk,
  input  wire logic       rst,
  // token input
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [1:0] kind, [4:2] punct_code, [5] is_inc_dec
  input  wire logic       s_tlast,   // last_token
  // verdict output
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [0] complete, [3:1] verdict
);

  localparam int DEPTH = scc_pkg::STACK_DEPTH;
  localparam int LW    = scc_pkg::LEVEL_W;

  // input fields
  logic [1:0] kind;
  logic [2:0] punct_code;
  logic       is_inc_dec;
  logic       in_acc;

  assign kind       = s_tdata[1:0];
  assign punct_code = s_tdata[4:2];
  assign is_inc_dec = s_tdata[5];
  assign in_acc     = s_tvalid && s_tready;

  // sequence state
  logic [LW-1:0] level, level_next;
  logic          mismatch, mismatch_next;
  logic          overflow, overflow_next;

  // stack cells, index 0 is the top
  logic [1:0]         cells [DEPTH];
  scc_pkg::cell_ctl_t ctl;

  // token decode
  logic is_punct, is_opener, is_closer, frozen, full, empty, top_match;

  always_comb begin
    is_punct  = (kind == scc_pkg::KIND_PUNCT);
    is_opener = is_punct && (punct_code == scc_pkg::P_LPAREN ||
                             punct_code == scc_pkg::P_LBRACE ||
                             punct_code == scc_pkg::P_LBRACK);
    is_closer = is_punct && (punct_code == scc_pkg::P_RPAREN ||
                             punct_code == scc_pkg::P_RBRACE ||
                             punct_code == scc_pkg::P_RBRACK);
    frozen    = mismatch || overflow;
    full      = (level == LW'(DEPTH));
    empty     = (level == '0);
    // closer code minus three gives its opener
    top_match = (cells[0] == 2'(punct_code - 3'd3));
  end

  // stack update
  always_comb begin
    ctl.push      = 1'b0;
    ctl.pop       = 1'b0;
    level_next    = level;
    mismatch_next = mismatch;
    overflow_next = overflow;
    if (in_acc && !frozen) begin
      if (is_opener) begin
        if (full) begin
          overflow_next = 1'b1;
        end else begin
          ctl.push   = 1'b1;
          level_next = level + 1'b1;
        end
      end else if (is_closer) begin
        if (empty || !top_match) begin
          mismatch_next = 1'b1;
        end else begin
          ctl.pop    = 1'b1;
          level_next = level - 1'b1;
        end
      end
    end
  end

  // verdict for the final token, from the state after its own bracket effect
  scc_pkg::verdict_t verdict;
  logic              complete;

  always_comb begin
    if (overflow_next) begin
      verdict = scc_pkg::V_OVERFLOW;
    end else if (mismatch_next || level_next != '0) begin
      verdict = scc_pkg::V_UNBAL;
    end else if (is_punct && (punct_code == scc_pkg::P_SEMI ||
                              punct_code == scc_pkg::P_RBRACE ||
                              punct_code == scc_pkg::P_LBRACE)) begin
      verdict = scc_pkg::V_TERM;
    end else if (kind == scc_pkg::KIND_ASSIGN && !is_inc_dec) begin
      verdict = scc_pkg::V_DANGLE;
    end else begin
      verdict = scc_pkg::V_COMPLETE;
    end
    complete = (verdict == scc_pkg::V_TERM) || (verdict == scc_pkg::V_COMPLETE);
  end

  // sequence state registers, cleared after every verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      mismatch <= 1'b0;
      overflow <= 1'b0;
    end else if (in_acc && s_tlast) begin
      level    <= '0;
      mismatch <= 1'b0;
      overflow <= 1'b0;
    end else begin
      level    <= level_next;
      mismatch <= mismatch_next;
      overflow <= overflow_next;
    end
  end

  // row of stack cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [1:0] up, down;
    if (i == 0) begin : g_top
      assign up = punct_code[1:0];
    end else begin : g_mid
      assign up = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign down = scc_pkg::OPEN_NONE;
    end else begin : g_above
      assign down = cells[i+1];
    end
    scc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_up   (up),
      .from_down (down),
      .entry     (cells[i])
    );
  end

  // output register with one skid entry
  logic       res_new;
  logic [3:0] res_data;
  logic       out_valid, skid_valid;
  logic [3:0] out_data, skid_data;

  assign res_new  = in_acc && s_tlast;
  assign res_data = {verdict, complete};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_new;
      end
    end else if (res_new) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_data <= skid_valid ? skid_data : res_data;
    end else if (res_new) begin
      skid_data <= res_data;
    end
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_data};

endmodule

`default_nettype wire

/* hdl/scc_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module scc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  logic [2:0] vcode;
  logic       code_ok;

  assign vcode   = m_tdata[3:1];
  assign code_ok = (vcode == scc_pkg::V_TERM) || (vcode == scc_pkg::V_COMPLETE);

  // a stalled verdict holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // complete flag agrees with the verdict code
  `ASSERT_IMPLY(a_complete_code, clk, rst, m_tvalid, m_tdata[0] == code_ok)

  // no verdict code beyond overflow, and the upper data bits stay zero
  `ASSERT_IMPLY(a_verdict_range, clk, rst, m_tvalid, vcode <= scc_pkg::V_OVERFLOW && m_tdata[7:4] == 4'd0)

  // input backpressure only with a verdict waiting
  `ASSERT_IMPLY(a_ready_low, clk, rst, !s_tready, m_tvalid)

  // no verdict appears without a final token
  `ASSERT_NEXT(a_no_spurious, clk, rst, !m_tvalid && !(s_tvalid && s_tready && s_tlast), !m_tvalid)

endmodule

bind statement_completeness_checker_core scc_checker u_scc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/scc_verdict_checker.sv */
`timescale 1ns / 100ps

module scc_verdict_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  output int         mismatches,
  output int         verdicts_due
);

  typedef struct {
    logic              complete;
    scc_pkg::verdict_t verdict;
  } verdict_item_t;

  verdict_item_t expected_verdicts[$];

  // bracket tracking, kept apart from the block
  logic [1:0] open_stack [scc_pkg::STACK_DEPTH];
  int         open_cnt;
  logic       close_err;
  logic       stack_over;

  function automatic logic [2:0] opener_for(input logic [2:0] closer);
    case (closer)
      scc_pkg::P_RPAREN: return scc_pkg::P_LPAREN;
      scc_pkg::P_RBRACE: return scc_pkg::P_LBRACE;
      default:           return scc_pkg::P_LBRACK;
    endcase
  endfunction

  task automatic clear_sequence();
    open_cnt   = 0;
    close_err  = 1'b0;
    stack_over = 1'b0;
  endtask

  task automatic predict_token(input logic [1:0] kind, input logic [2:0] code,
                               input logic inc_dec, input logic last);
    verdict_item_t     rec;
    scc_pkg::verdict_t v;
    // stack frozen once a mismatch or an overflow is latched
    if (kind == scc_pkg::KIND_PUNCT && !close_err && !stack_over) begin
      case (code)
        scc_pkg::P_LPAREN, scc_pkg::P_LBRACE, scc_pkg::P_LBRACK: begin
          if (open_cnt >= scc_pkg::STACK_DEPTH) begin
            stack_over = 1'b1;
          end else begin
            open_stack[open_cnt] = code[1:0];
            open_cnt++;
          end
        end
        scc_pkg::P_RPAREN, scc_pkg::P_RBRACE, scc_pkg::P_RBRACK: begin
          if (open_cnt == 0) begin
            close_err = 1'b1;
          end else if ({1'b0, open_stack[open_cnt-1]} != opener_for(code)) begin
            close_err = 1'b1;
          end else begin
            open_cnt--;
          end
        end
        default: ;
      endcase
    end
    if (last) begin
      if (stack_over) v = scc_pkg::V_OVERFLOW;
      else if (close_err || open_cnt != 0) v = scc_pkg::V_UNBAL;
      else if (kind == scc_pkg::KIND_PUNCT &&
               (code == scc_pkg::P_SEMI || code == scc_pkg::P_RBRACE ||
                code == scc_pkg::P_LBRACE)) v = scc_pkg::V_TERM;
      else if (kind == scc_pkg::KIND_ASSIGN && !inc_dec) v = scc_pkg::V_DANGLE;
      else v = scc_pkg::V_COMPLETE;
      rec.verdict  = v;
      rec.complete = (v == scc_pkg::V_TERM || v == scc_pkg::V_COMPLETE);
      expected_verdicts.insert(expected_verdicts.size(), rec);
      clear_sequence();
    end
  endtask

  initial begin
    mismatches   = 0;
    verdicts_due = 0;
    clear_sequence();
  end

  always @(posedge clk) begin
    verdict_item_t exp_item;
    if (rst) begin
      clear_sequence();
      expected_verdicts.delete();
    end else begin
      // results are checked before the token of this edge is predicted
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict item, expected none, actual %0d/%0d",
                   $time, m_tdata[0], m_tdata[3:1]);
          mismatches <= mismatches + 1;
        end else begin
          exp_item = expected_verdicts.pop_front();
          if (m_tdata[0] !== exp_item.complete || m_tdata[3:1] !== exp_item.verdict) begin
            $display("%0t: verdict item, expected %0d/%0d, actual %0d/%0d",
                     $time, exp_item.complete, exp_item.verdict,
                     m_tdata[0], m_tdata[3:1]);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_token(s_tdata[1:0], s_tdata[4:2], s_tdata[5], s_tlast);
    end
    verdicts_due <= expected_verdicts.size();
  end

endmodule

/* tb/tb_statement_completeness_checker_core.sv */
`timescale 1ns / 100ps

module tb_statement_completeness_checker_core;

  // token classes and codes the package leaves unnamed
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [2:0] P_NONE     = 3'd0;

  localparam int TOKEN_TARGET = 1400;
  localparam int CALM_TOKENS  = 200;   // tail of the run with no idling
  localparam int LONG_HOLD    = 200;   // receiver hold-off that fills the block
  localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 10;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;

  int mismatch_cnt;
  int verdicts_due;
  int tokens_sent;
  bit calm;
  bit hold_off_req;

  statement_completeness_checker_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // watches both channels, predicts verdicts and counts mismatches
  scc_verdict_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatch_cnt),
    .verdicts_due (verdicts_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one token and hold it until the block takes it; valid stays high
  // on return unless a random gap is taken, so a following token goes out back to back
  task automatic send_token(input logic [1:0] kind, input logic [2:0] code,
                            input logic inc_dec, input logic last);
    s_tdata  <= {2'b00, inc_dec, code, kind};
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    tokens_sent++;
    // random sender gap, never in the calm tail
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // sender pause: nothing new goes in until every verdict has come out
  task automatic wait_verdicts_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] closer_for(input logic [2:0] opener);
    case (opener)
      scc_pkg::P_LPAREN: return scc_pkg::P_RPAREN;
      scc_pkg::P_LBRACE: return scc_pkg::P_RBRACE;
      default:           return scc_pkg::P_RBRACK;
    endcase
  endfunction

  function automatic logic [1:0] rand_kind();
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic logic [2:0] rand_code();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [2:0] rand_opener();
    return 3'($urandom_range(scc_pkg::P_LPAREN, scc_pkg::P_LBRACK));
  endfunction

  // token with no bracket effect: other, spare kind, assignment, or bare punct
  task automatic send_filler();
    case ($urandom_range(0, 3))
      0:       send_token(KIND_OTHER, rand_code(), rand_bit(), 1'b0);
      1:       send_token(scc_pkg::KIND_ASSIGN, rand_code(), rand_bit(), 1'b0);
      2:       send_token(KIND_SPARE, rand_code(), rand_bit(), 1'b0);
      default: send_token(scc_pkg::KIND_PUNCT, P_NONE, rand_bit(), 1'b0);
    endcase
  endtask

  // nest down to the given depth and close again; past the stack depth the
  // block latches overflow and ignores the rest of the brackets
  task automatic send_deep(input int depth);
    logic [2:0] opens[$];
    logic [2:0] c;
    for (int i = 0; i < depth; i++) begin
      c = rand_opener();
      opens.insert(opens.size(), c);
      send_token(scc_pkg::KIND_PUNCT, c, rand_bit(), 1'b0);
    end
    while (opens.size() > 0)
      send_token(scc_pkg::KIND_PUNCT, closer_for(opens.pop_back()), rand_bit(), 1'b0);
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_SEMI, 1'b0, 1'b1);
  endtask

  // mostly well-nested sequences with random filler, some with a wrong
  // closer or a bracket left open, and some pure noise
  task automatic send_random_sequence();
    logic [2:0] opens[$];
    logic [2:0] c;
    int         mode;
    int         steps;
    int         len;
    mode = int'($urandom_range(0, 99));
    if (mode < 25) begin
      len = int'($urandom_range(1, 8));
      for (int i = 0; i < len; i++)
        send_token(rand_kind(), rand_code(), rand_bit(), i == len - 1);
    end else begin
      steps = int'($urandom_range(0, 12));
      for (int i = 0; i < steps; i++) begin
        case ($urandom_range(0, 2))
          0: begin
            if (opens.size() < 8) begin
              c = rand_opener();
              opens.insert(opens.size(), c);
              send_token(scc_pkg::KIND_PUNCT, c, rand_bit(), 1'b0);
            end else begin
              send_filler();
            end
          end
          1: begin
            if (opens.size() > 0) begin
              c = closer_for(opens.pop_back());
              // broken sequence: a random closer, often the wrong one
              if (mode < 37 && $urandom_range(0, 2) == 0)
                c = 3'($urandom_range(scc_pkg::P_RPAREN, scc_pkg::P_RBRACK));
              send_token(scc_pkg::KIND_PUNCT, c, rand_bit(), 1'b0);
            end else begin
              send_filler();
            end
          end
          default: send_filler();
        endcase
      end
      // leave a bracket open now and then
      if (mode < 40 && opens.size() > 0)
        void'(opens.pop_front());
      while (opens.size() > 0)
        send_token(scc_pkg::KIND_PUNCT, closer_for(opens.pop_back()), rand_bit(), 1'b0);
      // last token picks among terminator, assignment, other and anything
      case ($urandom_range(0, 3))
        0:       send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_SEMI, rand_bit(), 1'b1);
        1:       send_token(scc_pkg::KIND_ASSIGN, rand_code(), rand_bit(), 1'b1);
        2:       send_token(KIND_OTHER, rand_code(), rand_bit(), 1'b1);
        default: send_token(rand_kind(), rand_code(), rand_bit(), 1'b1);
      endcase
    end
  endtask

  // receiver: short random stalls, one long hold-off on request, none at the end
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold_left = int'($urandom_range(0, 3));
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: ends the run when no item moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int seq_no;
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tlast      <= 1'b0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    tokens_sent  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: lone terminator
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_SEMI, 1'b0, 1'b1);
    // matched parens, ends on an other token
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_LPAREN, 1'b0, 1'b0);
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_RPAREN, 1'b0, 1'b0);
    send_token(KIND_OTHER, P_NONE, 1'b0, 1'b1);
    // open brace left on the stack at the end
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_LBRACE, 1'b0, 1'b1);
    // closer on an empty stack
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_RBRACE, 1'b0, 1'b1);
    // closer of the wrong type
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_LBRACK, 1'b0, 1'b0);
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_RPAREN, 1'b0, 1'b1);
    // dangling assignment
    send_token(scc_pkg::KIND_ASSIGN, P_NONE, 1'b0, 1'b1);
    // increment ends complete, its punct code has no effect
    send_token(scc_pkg::KIND_ASSIGN, scc_pkg::P_RBRACE, 1'b1, 1'b1);
    // spare kind counts as other, even with a terminator code
    send_token(KIND_SPARE, scc_pkg::P_SEMI, 1'b1, 1'b1);
    // opener code on a non-punct token, then bare punct with no code
    send_token(KIND_OTHER, scc_pkg::P_LPAREN, 1'b1, 1'b0);
    send_token(scc_pkg::KIND_PUNCT, P_NONE, 1'b0, 1'b1);
    // nested brace and bracket, ends on the closing brace
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_LBRACE, 1'b0, 1'b0);
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_LBRACK, 1'b0, 1'b0);
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_RBRACK, 1'b0, 1'b0);
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_RBRACE, 1'b0, 1'b1);
    // mismatch freezes the stack, so the later matching closer is ignored
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_LPAREN, 1'b0, 1'b0);
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_RBRACK, 1'b0, 1'b0);
    send_token(scc_pkg::KIND_PUNCT, scc_pkg::P_RPAREN, 1'b0, 1'b0);
    send_token(scc_pkg::KIND_ASSIGN, scc_pkg::P_SEMI, 1'b0, 1'b1);

    // long receiver hold-off while single-token sequences keep coming, so
    // the output entries fill and the input stalls
    hold_off_req = 1'b1;
    for (int i = 0; i < 16; i++)
      send_token(rand_kind(), rand_code(), rand_bit(), 1'b1);
    wait_verdicts_drained();

    // stack filled exactly, then one push past it
    send_deep(scc_pkg::STACK_DEPTH);
    send_deep(scc_pkg::STACK_DEPTH + 1);

    seq_no = 0;
    while (tokens_sent < TOKEN_TARGET) begin
      seq_no++;
      if (tokens_sent >= TOKEN_TARGET - CALM_TOKENS) calm = 1'b1;
      if (seq_no % 97 == 0)
        send_deep(int'($urandom_range(scc_pkg::STACK_DEPTH - 3, scc_pkg::STACK_DEPTH + 4)));
      else send_random_sequence();
      if (seq_no % 50 == 0) wait_verdicts_drained();
    end

    wait_verdicts_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
